// File: design/tdpt_pkg.sv
package tdpt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    // microprogram addresses
    typedef enum logic [2:0] {
        ST_WAIT  = 3'd0,
        ST_SMALL = 3'd1,
        ST_DINIT = 3'd2,
        ST_DSTEP = 3'd3,
        ST_BOUND = 3'd4,
        ST_REMT  = 3'd5,
        ST_PASS  = 3'd6,
        ST_FAIL  = 3'd7
    } step_t;

    // branch conditions
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_NO_REQ   = 3'd1,
        C_SMALL    = 3'd2,
        C_DIV_MORE = 3'd3,
        C_D_GT_Q   = 3'd4,
        C_REM_NZ   = 3'd5,
        C_OUT_BUSY = 3'd6
    } cond_t;

    typedef struct packed {
        cond_t cond;
        step_t jump_to;   // taken when cond holds
        step_t next_to;   // taken otherwise
        logic  s_ready;
        logic  div_init;
        logic  div_step;
        logic  d_inc;
        logic  push;
        logic  res_val;
    } ctrl_t;

    typedef struct packed {
        logic no_req;
        logic small_val;
        logic div_more;
        logic d_gt_q;
        logic rem_nz;
        logic out_busy;
    } flags_t;

    function automatic ctrl_t ucode(input step_t pc);
        ctrl_t w;
        begin
            w = '{cond: C_NEVER, jump_to: ST_WAIT, next_to: ST_WAIT, default: 1'b0};
            case (pc)
                ST_WAIT: begin
                    w.cond = C_NO_REQ; w.jump_to = ST_WAIT; w.next_to = ST_SMALL;
                    w.s_ready = 1'b1;
                end
                ST_SMALL: begin
                    w.cond = C_SMALL; w.jump_to = ST_FAIL; w.next_to = ST_DINIT;
                end
                ST_DINIT: begin
                    w.cond = C_NEVER; w.jump_to = ST_DSTEP; w.next_to = ST_DSTEP;
                    w.div_init = 1'b1;
                end
                ST_DSTEP: begin
                    w.cond = C_DIV_MORE; w.jump_to = ST_DSTEP; w.next_to = ST_BOUND;
                    w.div_step = 1'b1;
                end
                ST_BOUND: begin
                    w.cond = C_D_GT_Q; w.jump_to = ST_PASS; w.next_to = ST_REMT;
                end
                ST_REMT: begin
                    w.cond = C_REM_NZ; w.jump_to = ST_DINIT; w.next_to = ST_FAIL;
                    w.d_inc = 1'b1;
                end
                ST_PASS: begin
                    w.cond = C_OUT_BUSY; w.jump_to = ST_PASS; w.next_to = ST_WAIT;
                    w.push = 1'b1; w.res_val = 1'b1;
                end
                ST_FAIL: begin
                    w.cond = C_OUT_BUSY; w.jump_to = ST_FAIL; w.next_to = ST_WAIT;
                    w.push = 1'b1; w.res_val = 1'b0;
                end
                default: begin
                    w.cond = C_NEVER; w.jump_to = ST_WAIT; w.next_to = ST_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

// File: design/tdpt_seq.sv
module tdpt_seq import tdpt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t pc_reg, pc_next;
    logic  taken;

    always_comb begin
        ctrl = ucode(pc_reg);
    end

    always_comb begin
        case (ctrl.cond)
            C_NEVER:    taken = 1'b0;
            C_NO_REQ:   taken = flags.no_req;
            C_SMALL:    taken = flags.small_val;
            C_DIV_MORE: taken = flags.div_more;
            C_D_GT_Q:   taken = flags.d_gt_q;
            C_REM_NZ:   taken = flags.rem_nz;
            C_OUT_BUSY: taken = flags.out_busy;
            default:    taken = 1'b0;
        endcase
        pc_next = taken ? ctrl.jump_to : ctrl.next_to;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= ST_WAIT;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: design/tdpt_dp.sv
module tdpt_dp import tdpt_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  ctrl_t  ctrl,
    input  logic   s_valid,
    input  word_t  s_value,
    input  logic   m_ready,
    output logic   m_valid,
    output logic   m_is_prime,
    output flags_t flags
);

    word_t n_reg, n_next;
    word_t d_reg, d_next;
    word_t rem_reg, rem_next;
    word_t quo_reg, quo_next;
    cnt_t  cnt_reg, cnt_next;
    logic  m_valid_reg, m_valid_next;
    logic  res_reg, res_next;

    logic                  load;
    logic [DATA_WIDTH:0]   trial;
    logic                  out_busy;

    assign load     = ctrl.s_ready && s_valid;
    assign out_busy = m_valid_reg && !m_ready;
    // one restoring-division bit per step
    assign trial    = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, d_reg};

    always_comb begin
        n_next   = n_reg;
        d_next   = d_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (load) begin
            n_next = s_value;
            d_next = DATA_WIDTH'(2);
        end
        if (ctrl.div_init) begin
            rem_next = '0;
            quo_next = n_reg;
            cnt_next = CNT_W'(DATA_WIDTH);
        end
        if (ctrl.div_step) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (!trial[DATA_WIDTH]) begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
        if (ctrl.d_inc) begin
            d_next = d_reg + DATA_WIDTH'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        if (ctrl.push && !out_busy) begin
            m_valid_next = 1'b1;
            res_next     = ctrl.res_val;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        flags.no_req    = !s_valid;
        // negative, zero or one
        flags.small_val = n_reg[DATA_WIDTH-1] || (n_reg[DATA_WIDTH-1:1] == '0);
        flags.div_more  = (cnt_reg != CNT_W'(1));
        // d > n/d means d*d > n: no divisor left to try
        flags.d_gt_q    = (d_reg > quo_reg);
        flags.rem_nz    = (rem_reg != '0);
        flags.out_busy  = out_busy;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = res_reg;

endmodule

// File: design/trial_division_prime_test.sv
// Trial-division primality test, one request at a time under a microcoded sequencer.
// Each trial divisor, starting from 2, is tested by the bit-serial remainder unit.
// Values below 2 (negative, zero or one) are reported not prime without any division; a
// composite ends at its smallest factor p; a prime n passes once the trial divisor d exceeds
// n/d. Next request is taken on return to wait.
// Reset (aresetn low, synchronous) returns the sequencer to wait and empties the output.
module trial_division_prime_test import tdpt_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_prime
);

    ctrl_t  ctrl;
    flags_t flags;
    word_t  value_bits;

    assign value_bits = word_t'(s_value);
    assign s_ready    = ctrl.s_ready;

    tdpt_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    tdpt_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .s_valid    (s_valid),
        .s_value    (value_bits),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_is_prime (m_is_prime),
        .flags      (flags)
    );

endmodule
